/* hdl/c8x_pkg.sv */
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types and constants for the CHIP-8 instruction execute block.
// ----------------------------------------------------------------------------
package c8x_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;

	localparam logic [11:0] PC_RESET = 12'd512;
	localparam logic [11:0] PC_STEP  = 12'd2;
	localparam logic [3:0]  VF_NUM   = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [7:0] KK_SKP  = 8'h9E;
	localparam logic [7:0] KK_SKNP = 8'hA1;

	// top nibble of the opcode
	localparam logic [3:0] GRP_SYS  = 4'h0;
	localparam logic [3:0] GRP_JP   = 4'h1;
	localparam logic [3:0] GRP_CALL = 4'h2;
	localparam logic [3:0] GRP_SE   = 4'h3;
	localparam logic [3:0] GRP_SNE  = 4'h4;
	localparam logic [3:0] GRP_SER  = 4'h5;
	localparam logic [3:0] GRP_LD   = 4'h6;
	localparam logic [3:0] GRP_ADD  = 4'h7;
	localparam logic [3:0] GRP_ALU  = 4'h8;
	localparam logic [3:0] GRP_SNER = 4'h9;
	localparam logic [3:0] GRP_LDI  = 4'hA;
	localparam logic [3:0] GRP_JPV0 = 4'hB;
	localparam logic [3:0] GRP_RND  = 4'hC;
	localparam logic [3:0] GRP_DRW  = 4'hD;
	localparam logic [3:0] GRP_KEY  = 4'hE;
	localparam logic [3:0] GRP_MISC = 4'hF;

	// low nibble of the 8xy_ group
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	localparam logic [3:0] NIB_ZERO = 4'h0;

	typedef enum logic [1:0] {
		ST_EXEC  = 2'd0,
		ST_CLS   = 2'd1,
		ST_UNREC = 2'd2,
		ST_DEFER = 2'd3
	} c8x_status_t;

	// register file write for one executed instruction
	typedef struct packed {
		logic       mem_en;
		logic [3:0] mem_addr;
		logic [7:0] mem_val;
		logic       vf_en;
		logic [7:0] vf_val;
	} c8x_vwr_t;

endpackage

/* hdl/c8x_vregfile.sv */
// ----------------------------------------------------------------------------
// c8x_vregfile
// V register file: V0-VE in a memory with registered reads and write bypass,
// VF and a copy of V0 in flops. Operands line up with the execute stage.
// ----------------------------------------------------------------------------
module c8x_vregfile (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [3:0]       rd_x,
	input  logic [3:0]       rd_y,
	input  c8x_pkg::c8x_vwr_t wr,
	output logic [7:0]       vx,
	output logic [7:0]       vy,
	output logic [7:0]       v0
);

	logic [7:0]  mem_q [16];
	logic [15:0] vld_q;
	logic [7:0]  vf_q;
	logic [7:0]  v0_q;
	logic [7:0]  memx_s1;
	logic [7:0]  memy_s1;
	logic [7:0]  byp_s1;
	logic [3:0]  x_s1;
	logic [3:0]  y_s1;
	logic        hitx_s1;
	logic        hity_s1;

	always_ff @(posedge clk) begin
		if (wr.mem_en) begin
			mem_q[wr.mem_addr] <= wr.mem_val;
		end
		if (rd_en) begin
			memx_s1 <= mem_q[rd_x];
			memy_s1 <= mem_q[rd_y];
			byp_s1  <= wr.mem_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vf_q    <= '0;
			v0_q    <= '0;
			x_s1    <= '0;
			y_s1    <= '0;
			hitx_s1 <= 1'b0;
			hity_s1 <= 1'b0;
		end else begin
			if (wr.mem_en) begin
				vld_q[wr.mem_addr] <= 1'b1;
				if (wr.mem_addr == 4'd0) begin
					v0_q <= wr.mem_val;
				end
			end
			if (wr.vf_en) begin
				vf_q <= wr.vf_val;
			end
			if (rd_en) begin
				x_s1    <= rd_x;
				y_s1    <= rd_y;
				// a write landing on the same edge misses the registered read
				hitx_s1 <= wr.mem_en && (wr.mem_addr == rd_x);
				hity_s1 <= wr.mem_en && (wr.mem_addr == rd_y);
			end
		end
	end

	always_comb begin
		if (x_s1 == c8x_pkg::VF_NUM) begin
			vx = vf_q;
		end else if (hitx_s1) begin
			vx = byp_s1;
		end else if (vld_q[x_s1]) begin
			vx = memx_s1;
		end else begin
			vx = '0;
		end
		if (y_s1 == c8x_pkg::VF_NUM) begin
			vy = vf_q;
		end else if (hity_s1) begin
			vy = byp_s1;
		end else if (vld_q[y_s1]) begin
			vy = memy_s1;
		end else begin
			vy = '0;
		end
	end

	assign v0 = v0_q;

endmodule

/* hdl/chip8_alu_branch_execute.sv */
// ----------------------------------------------------------------------------
// chip8_alu_branch_execute
// Executes one CHIP-8 opcode per word: jumps, calls, returns, skips, loads,
// ALU ops with VF flags, Annn, Bnnn and Cxkk.
// ----------------------------------------------------------------------------
// The block takes one instruction word per cycle while its output is not
// stalled and gives one result word for each, in order. An accepted word sits
// in an input register while the decode, ALU and program counter logic work
// on it; its result is loaded into the output register once that register is
// free, that is, when it is empty or its result is being taken.
// The state (V registers, program counter, index, return stack) updates at
// the edge that loads the result, so the next word already sees it and words
// may follow each other every cycle unless stalled. V0-VE live in a register
// memory read when a word is accepted, with a bypass for the word finishing
// on that edge. Display, keypad, timer and Fx memory opcodes come back as
// deferred and change nothing but the program counter. The return stack has
// STACK_DEPTH entries and wraps on overflow and underflow.
// ----------------------------------------------------------------------------
module chip8_alu_branch_execute #(
	parameter int unsigned STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] opcode,
	input  logic [7:0]  random_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [11:0] next_pc,
	output logic [11:0] index_value,
	output logic        reg_write,
	output logic [3:0]  reg_number,
	output logic [7:0]  reg_value
);

	localparam int unsigned SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

	logic        in_fire;
	logic        exec_fire;
	logic        vld_s1;
	logic [15:0] op_s1;
	logic [7:0]  rnd_s1;

	logic        out_vld_q;
	c8x_pkg::c8x_status_t status_q;
	logic [11:0] next_pc_q;
	logic [11:0] index_q;
	logic        reg_write_q;
	logic [3:0]  reg_number_q;
	logic [7:0]  reg_value_q;

	logic [11:0] pc_q;
	logic [11:0] idx_q;
	logic [SP_W-1:0] sp_q;
	logic [11:0] stack_q [STACK_DEPTH];

	logic [7:0]  vx;
	logic [7:0]  vy;
	logic [7:0]  v0;
	c8x_pkg::c8x_vwr_t vwr;

	logic [3:0]  op_grp;
	logic [3:0]  op_x;
	logic [3:0]  op_n;
	logic [7:0]  op_kk;
	logic [11:0] op_nnn;
	logic [11:0] pc_inc;
	logic [11:0] pc_skip;
	logic [SP_W-1:0] sp_inc;
	logic [SP_W-1:0] sp_dec;
	logic [8:0]  sum9;

	c8x_pkg::c8x_status_t st_d;
	logic [11:0] pc_d;
	logic [11:0] idx_d;
	logic [SP_W-1:0] sp_d;
	logic        push;
	logic        wx_en;
	logic [7:0]  wx_val;
	logic        wf_en;
	logic        wf_bit;
	logic        wr_any;
	logic [3:0]  wr_num;
	logic [7:0]  wr_val;

	// handshake: the output register parts the two sides
	assign exec_fire = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready  = !vld_s1 || exec_fire;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_fire) begin
				vld_s1 <= 1'b1;
			end else if (exec_fire) begin
				vld_s1 <= 1'b0;
			end
			if (exec_fire) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= opcode;
			rnd_s1 <= random_byte;
		end
	end

	c8x_vregfile u_vregs (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_fire),
		.rd_x   (opcode[11:8]),
		.rd_y   (opcode[7:4]),
		.wr     (vwr),
		.vx     (vx),
		.vy     (vy),
		.v0     (v0)
	);

	assign op_grp  = op_s1[15:12];
	assign op_x    = op_s1[11:8];
	assign op_n    = op_s1[3:0];
	assign op_kk   = op_s1[7:0];
	assign op_nnn  = op_s1[11:0];
	assign pc_inc  = pc_q + c8x_pkg::PC_STEP;
	assign pc_skip = pc_inc + c8x_pkg::PC_STEP;
	assign sp_inc  = (sp_q == SP_LAST) ? '0 : sp_q + 1'b1;
	assign sp_dec  = (sp_q == '0) ? SP_LAST : sp_q - 1'b1;
	assign sum9    = {1'b0, vx} + {1'b0, vy};

	always_comb begin
		st_d   = c8x_pkg::ST_EXEC;
		pc_d   = pc_inc;
		idx_d  = idx_q;
		sp_d   = sp_q;
		push   = 1'b0;
		wx_en  = 1'b0;
		wx_val = '0;
		wf_en  = 1'b0;
		wf_bit = 1'b0;
		case (op_grp)
			c8x_pkg::GRP_SYS: begin
				if (op_s1 == c8x_pkg::OP_CLS) begin
					st_d = c8x_pkg::ST_CLS;
				end else if (op_s1 == c8x_pkg::OP_RET) begin
					sp_d = sp_dec;
					pc_d = stack_q[sp_dec];
				end
			end
			c8x_pkg::GRP_JP: begin
				pc_d = op_nnn;
			end
			c8x_pkg::GRP_CALL: begin
				push = 1'b1;
				sp_d = sp_inc;
				pc_d = op_nnn;
			end
			c8x_pkg::GRP_SE: begin
				if (vx == op_kk) begin
					pc_d = pc_skip;
				end
			end
			c8x_pkg::GRP_SNE: begin
				if (vx != op_kk) begin
					pc_d = pc_skip;
				end
			end
			c8x_pkg::GRP_SER: begin
				if (op_n != c8x_pkg::NIB_ZERO) begin
					st_d = c8x_pkg::ST_UNREC;
				end else if (vx == vy) begin
					pc_d = pc_skip;
				end
			end
			c8x_pkg::GRP_LD: begin
				wx_en  = 1'b1;
				wx_val = op_kk;
			end
			c8x_pkg::GRP_ADD: begin
				wx_en  = 1'b1;
				wx_val = vx + op_kk;
			end
			c8x_pkg::GRP_ALU: begin
				case (op_n)
					c8x_pkg::ALU_MOV: begin
						wx_en  = 1'b1;
						wx_val = vy;
					end
					c8x_pkg::ALU_OR: begin
						wx_en  = 1'b1;
						wx_val = vx | vy;
					end
					c8x_pkg::ALU_AND: begin
						wx_en  = 1'b1;
						wx_val = vx & vy;
					end
					c8x_pkg::ALU_XOR: begin
						wx_en  = 1'b1;
						wx_val = vx ^ vy;
					end
					c8x_pkg::ALU_ADD: begin
						wx_en  = 1'b1;
						wx_val = sum9[7:0];
						wf_en  = 1'b1;
						wf_bit = sum9[8];
					end
					c8x_pkg::ALU_SUB: begin
						wx_en  = 1'b1;
						wx_val = vx - vy;
						wf_en  = 1'b1;
						wf_bit = (vx >= vy);
					end
					c8x_pkg::ALU_SHR: begin
						wx_en  = 1'b1;
						wx_val = {1'b0, vx[7:1]};
						wf_en  = 1'b1;
						wf_bit = vx[0];
					end
					c8x_pkg::ALU_SUBN: begin
						wx_en  = 1'b1;
						wx_val = vy - vx;
						wf_en  = 1'b1;
						wf_bit = (vy >= vx);
					end
					c8x_pkg::ALU_SHL: begin
						wx_en  = 1'b1;
						wx_val = {vx[6:0], 1'b0};
						wf_en  = 1'b1;
						wf_bit = vx[7];
					end
					default: begin
						st_d = c8x_pkg::ST_UNREC;
					end
				endcase
			end
			c8x_pkg::GRP_SNER: begin
				if (op_n != c8x_pkg::NIB_ZERO) begin
					st_d = c8x_pkg::ST_UNREC;
				end else if (vx != vy) begin
					pc_d = pc_skip;
				end
			end
			c8x_pkg::GRP_LDI: begin
				idx_d = op_nnn;
			end
			c8x_pkg::GRP_JPV0: begin
				pc_d = op_nnn + {4'd0, v0};
			end
			c8x_pkg::GRP_RND: begin
				wx_en  = 1'b1;
				wx_val = rnd_s1 & op_kk;
			end
			c8x_pkg::GRP_DRW: begin
				st_d = c8x_pkg::ST_DEFER;
			end
			c8x_pkg::GRP_KEY: begin
				if (op_kk == c8x_pkg::KK_SKP || op_kk == c8x_pkg::KK_SKNP) begin
					st_d = c8x_pkg::ST_DEFER;
				end else begin
					st_d = c8x_pkg::ST_UNREC;
				end
			end
			default: begin
				st_d = c8x_pkg::ST_DEFER;
			end
		endcase
	end

	// the flag has priority over the result for VF, so it wins when x is F
	assign wr_any = wx_en || wf_en;
	assign wr_num = wf_en ? c8x_pkg::VF_NUM : (wx_en ? op_x : 4'd0);
	assign wr_val = wf_en ? {7'd0, wf_bit} : (wx_en ? wx_val : 8'd0);

	always_comb begin
		vwr.mem_en   = exec_fire && wx_en && (op_x != c8x_pkg::VF_NUM);
		vwr.mem_addr = op_x;
		vwr.mem_val  = wx_val;
		vwr.vf_en    = exec_fire && (wf_en || (wx_en && op_x == c8x_pkg::VF_NUM));
		vwr.vf_val   = wf_en ? {7'd0, wf_bit} : wx_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= c8x_pkg::PC_RESET;
			idx_q <= '0;
			sp_q  <= '0;
		end else if (exec_fire) begin
			pc_q  <= pc_d;
			idx_q <= idx_d;
			sp_q  <= sp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire && push) begin
			stack_q[sp_q] <= pc_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q     <= st_d;
			next_pc_q    <= pc_d;
			index_q      <= idx_d;
			reg_write_q  <= wr_any;
			reg_number_q <= wr_num;
			reg_value_q  <= wr_val;
		end
	end

	assign out_valid   = out_vld_q;
	assign status      = status_q;
	assign next_pc     = next_pc_q;
	assign index_value = index_q;
	assign reg_write   = reg_write_q;
	assign reg_number  = reg_number_q;
	assign reg_value   = reg_value_q;

	// an executed word always reaches the output register
	a_exec_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> out_vld_q)
		else $error("executed word did not reach the output register");

	// architectural state moves only when a word executes
	a_pc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_fire |=> $stable(pc_q) && $stable(idx_q) && $stable(sp_q))
		else $error("state changed without an executed word");

	// a stalled word in the execute stage is neither lost nor replaced
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !exec_fire |=> vld_s1 && $stable(op_s1))
		else $error("execute stage word changed while stalled");

	// unrecognised and deferred opcodes never write a V register
	a_no_write_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && (st_d == c8x_pkg::ST_UNREC || st_d == c8x_pkg::ST_DEFER)
			|-> !wr_any && !push && !vwr.mem_en && !vwr.vf_en)
		else $error("rejected opcode wrote state");

	// the return stack pointer stays inside the stack
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> (int'(sp_q) < STACK_DEPTH))
		else $error("stack pointer out of range");

endmodule
